// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define FDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/fdc_pkg.sv -----
`default_nettype none

package fdc_pkg;

  // Default configuration
  localparam int NUM_DRIVES_DEF        = 2;
  localparam int MAX_PARAM_BYTES_DEF   = 9;
  localparam int MAX_RESULT_BYTES_DEF  = 10;
  localparam int SEEK_STATUS_READS_DEF = 3;

  // Fixed field widths
  localparam int RI_W   = 4;   // result index and result total
  localparam int SEEK_W = 2;   // seek countdown
  localparam int BIDX_W = 17;  // block index

  // Bus access kind
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // Register offsets
  typedef enum logic [2:0] {
    OFF_SRA    = 3'd0,
    OFF_SRB    = 3'd1,
    OFF_DOR    = 3'd2,
    OFF_TAPE   = 3'd3,
    OFF_MSR    = 3'd4,
    OFF_FIFO   = 3'd5,
    OFF_UNUSED = 3'd6,
    OFF_DIR    = 3'd7
  } reg_off_e;

  // Supported opcodes
  localparam logic [4:0] OP_SPECIFY       = 5'd3;
  localparam logic [4:0] OP_READ_DATA     = 5'd6;
  localparam logic [4:0] OP_RECALIBRATE   = 5'd7;
  localparam logic [4:0] OP_SENSE_INT     = 5'd8;
  localparam logic [4:0] OP_SEEK          = 5'd15;
  localparam logic [4:0] OP_PERPENDICULAR = 5'd18;
  localparam logic [4:0] OP_CONFIGURE     = 5'd19;

  // Status byte bits
  localparam logic [7:0] ST0_SEEK_END = 8'h20;
  localparam logic [7:0] ST0_INT_CODE = 8'hC0;
  localparam logic [7:0] ST0_US_MASK  = 8'h03;
  localparam logic [7:0] SENSE_NO_INT = 8'h80;

  // Controller states
  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } ctrl_state_e;

  // Controller to datapath command
  typedef struct packed {
    logic exec;
  } ctrl_cmd_t;

  // Parameter bytes each opcode takes, opcode byte included
  function automatic logic [3:0] op_param_len(input logic [4:0] op);
    logic [3:0] len;
    unique case (op)
      5'd2, 5'd5, 5'd6, 5'd9, 5'd12, 5'd17, 5'd22, 5'd25, 5'd29: len = 4'd9;
      5'd3, 5'd15:                                                len = 4'd3;
      5'd4, 5'd7, 5'd10, 5'd18:                                   len = 4'd2;
      5'd8, 5'd14, 5'd16, 5'd20:                                  len = 4'd1;
      5'd13:                                                      len = 4'd6;
      5'd19:                                                      len = 4'd4;
      default:                                                    len = 4'd0;
    endcase
    return len;
  endfunction

  // Result bytes each opcode returns
  function automatic logic [3:0] op_result_len(input logic [4:0] op);
    logic [3:0] len;
    unique case (op)
      5'd2, 5'd5, 5'd6, 5'd9, 5'd10, 5'd12, 5'd13, 5'd17, 5'd22, 5'd25, 5'd29:
        len = 4'd7;
      5'd4, 5'd16, 5'd20: len = 4'd1;
      5'd8:               len = 4'd2;
      5'd14:              len = 4'd10;
      default:            len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- sv/fdc_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"

module fdc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output fdc_pkg::ctrl_cmd_t     cmd_o
);
  import fdc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  // Stall input only while a held item cannot leave
  assign in_stall_o  = (state_q == ST_FULL) && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_FULL);
  assign cmd_o.exec  = accept;

  // Track the output register
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (accept) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (accept) state_d = ST_FULL;
        else if (!out_stall_i) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  `FDC_ASSERT_NEXT(a_accept_fills, cmd_o.exec, out_valid_o, "accepted item not presented")
  `FDC_ASSERT_NEXT(a_drain_empties, out_valid_o && !out_stall_i && !cmd_o.exec, !out_valid_o, "taken item presented again")

endmodule

`default_nettype wire

// ----- sv/fdc_datapath.sv -----
`default_nettype none
`include "assert_macros.svh"

module fdc_datapath #(
  parameter int NUM_DRIVES        = fdc_pkg::NUM_DRIVES_DEF,
  parameter int MAX_PARAM_BYTES   = fdc_pkg::MAX_PARAM_BYTES_DEF,
  parameter int MAX_RESULT_BYTES  = fdc_pkg::MAX_RESULT_BYTES_DEF,
  parameter int SEEK_STATUS_READS = fdc_pkg::SEEK_STATUS_READS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fdc_pkg::ctrl_cmd_t         cmd_i,
  input  wire logic                       command_i,
  input  wire logic [2:0]                 reg_offset_i,
  input  wire logic [7:0]                 write_data_i,
  output logic [7:0]                      read_data_o,
  output logic                            block_request_o,
  output logic [fdc_pkg::BIDX_W-1:0]      block_index_o,
  output logic                            interrupt_pending_o,
  output logic                            motor_a_o,
  output logic                            motor_b_o,
  output logic                            dma_enable_o,
  output logic [1:0]                      unit_select_o,
  output logic [1:0]                      data_rate_o,
  output logic [2:0]                      precomp_code_o,
  output logic                            command_error_o
);
  import fdc_pkg::*;

  localparam int PCW = $clog2(MAX_PARAM_BYTES + 1);
  localparam int RIW = $clog2(MAX_RESULT_BYTES);
  localparam logic [SEEK_W-1:0] SEEK_LOAD = SEEK_W'(SEEK_STATUS_READS);

  // Command state
  logic [7:0]        pb_q [MAX_PARAM_BYTES];
  logic [7:0]        pb_d [MAX_PARAM_BYTES];
  logic [PCW-1:0]    pcnt_q, pcnt_d;
  logic [7:0]        rb_q [MAX_RESULT_BYTES];
  logic [7:0]        rb_d [MAX_RESULT_BYTES];
  logic [RI_W-1:0]   ridx_q, ridx_d;
  logic [RI_W-1:0]   rtot_q, rtot_d;
  logic              rqm_q, rqm_d;
  logic              dio_q, dio_d;
  logic              irq_q, irq_d;
  logic [SEEK_W-1:0] seek_q [NUM_DRIVES];
  logic [SEEK_W-1:0] seek_d [NUM_DRIVES];
  logic [SEEK_W-1:0] seek_dec [NUM_DRIVES];
  logic [7:0]        cyl_q [NUM_DRIVES];
  logic [7:0]        cyl_d [NUM_DRIVES];

  // Control bits
  logic              motor_a_q, motor_a_d;
  logic              motor_b_q, motor_b_d;
  logic              dma_q, dma_d;
  logic [1:0]        dsel_q, dsel_d;
  logic [1:0]        rate_q, rate_d;
  logic [2:0]        precomp_q, precomp_d;

  // Result register
  logic [7:0]        rd_q, rd_d;
  logic              breq_q, breq_d;
  logic [BIDX_W-1:0] bidx_q, bidx_d;
  logic              err_q, err_d;

  // Decode helpers
  reg_off_e          off;
  logic [7:0]        pv [7];
  logic [4:0]        op;
  logic [3:0]        plen, rlen;
  logic [PCW-1:0]    cnt_inc;
  logic [7:0]        sel_cyl;
  logic [7:0]        c, h, r, eot, nc, nh, nr, r_inc;
  logic [6:0]        half_eot;
  logic [15:0]       prod_c;
  logic [14:0]       prod_h;
  logic [BIDX_W-1:0] idx_sum;
  logic [3:0]        seeking;
  logic              busy;
  logic [7:0]        status;
  logic [7:0]        rb_rd;
  logic [RI_W-1:0]   ridx_inc;

  // Parameter bytes as seen with the incoming byte merged in
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      pv[i] = (pcnt_q == PCW'(i)) ? write_data_i : pb_q[i];
    end
  end

  assign off     = reg_off_e'(reg_offset_i);
  assign op      = pv[0][4:0];
  assign plen    = op_param_len(op);
  assign rlen    = op_result_len(op);
  assign cnt_inc = pcnt_q + 1'b1;

  // Cylinder of the selected drive, zero when absent
  always_comb begin
    sel_cyl = 8'd0;
    for (int i = 0; i < NUM_DRIVES; i++) begin
      if (32'(dsel_q) == i) sel_cyl = cyl_q[i];
    end
  end

  // Block address and next sector, head and cylinder
  assign c        = pv[2];
  assign h        = pv[3];
  assign r        = pv[4];
  assign eot      = pv[6];
  assign half_eot = eot[7:1];
  assign prod_c   = c * eot;
  assign prod_h   = h * half_eot;
  assign idx_sum  = BIDX_W'(prod_c) + BIDX_W'(prod_h) + BIDX_W'(r) - BIDX_W'(1);
  assign r_inc    = r + 8'd1;

  always_comb begin
    nc = c;
    nh = h;
    nr = r_inc;
    if (r_inc > {1'b0, half_eot}) begin
      nr = 8'd1;
      nh = h + 8'd1;
      if (nh > 8'd1) begin
        nh = 8'd0;
        nc = c + 8'd1;
      end
    end
  end

  // Main status: count seeks down, then report
  always_comb begin
    seeking = 4'd0;
    for (int i = 0; i < NUM_DRIVES; i++) begin
      seek_dec[i] = (seek_q[i] != '0) ? seek_q[i] - 1'b1 : seek_q[i];
      seeking[i]  = (seek_dec[i] != '0);
    end
  end

  assign busy   = (seeking != 4'd0) || (dio_q && rqm_q);
  assign status = {rqm_q, dio_q, 1'b0, busy, seeking};

  // Result byte at the read pointer
  assign rb_rd    = (32'(ridx_q) < MAX_RESULT_BYTES) ? rb_q[ridx_q[RIW-1:0]] : 8'd0;
  assign ridx_inc = (ridx_q != {RI_W{1'b1}}) ? ridx_q + 1'b1 : ridx_q;

  // Execute one bus access
  always_comb begin
    logic done;
    done      = 1'b1;
    pb_d      = pb_q;
    pcnt_d    = pcnt_q;
    rb_d      = rb_q;
    ridx_d    = ridx_q;
    rtot_d    = rtot_q;
    rqm_d     = rqm_q;
    dio_d     = dio_q;
    irq_d     = irq_q;
    seek_d    = seek_q;
    cyl_d     = cyl_q;
    motor_a_d = motor_a_q;
    motor_b_d = motor_b_q;
    dma_d     = dma_q;
    dsel_d    = dsel_q;
    rate_d    = rate_q;
    precomp_d = precomp_q;
    rd_d      = 8'd0;
    breq_d    = 1'b0;
    bidx_d    = '0;
    err_d     = 1'b0;

    if (cmd_i.exec) begin
      if (command_i == ACC_WRITE) begin
        unique case (off)
          OFF_DOR: begin
            motor_a_d = write_data_i[4];
            motor_b_d = write_data_i[5];
            dma_d     = write_data_i[3];
            dsel_d    = write_data_i[1:0];
          end
          OFF_MSR: begin
            rate_d    = write_data_i[1:0];
            precomp_d = write_data_i[4:2];
          end
          OFF_DIR: begin
            rate_d = write_data_i[1:0];
          end
          OFF_FIFO: begin
            // Drop bytes while results are pending
            if (!dio_q) begin
              for (int i = 0; i < MAX_PARAM_BYTES; i++) begin
                if (32'(pcnt_q) == i) pb_d[i] = write_data_i;
              end
              pcnt_d = cnt_inc;
              rtot_d = rlen;
              if (plen == 4'd0) begin
                pcnt_d = '0;
                err_d  = 1'b1;
              end else if (cnt_inc == PCW'(plen)) begin
                pcnt_d = '0;
                unique case (op)
                  OP_SPECIFY: begin
                    dma_d = ~pv[2][0];
                  end
                  OP_READ_DATA: begin
                    breq_d  = 1'b1;
                    bidx_d  = idx_sum;
                    pb_d[2] = nc;
                    pb_d[3] = nh;
                    pb_d[4] = nr;
                    rb_d[0] = (pv[1] & ST0_US_MASK) | ST0_SEEK_END | ST0_INT_CODE;
                    rb_d[1] = 8'd0;
                    rb_d[2] = 8'd0;
                    rb_d[3] = nc;
                    rb_d[4] = nh;
                    rb_d[5] = nr;
                    rb_d[6] = pv[5];
                    for (int i = 0; i < NUM_DRIVES; i++) begin
                      if (32'(dsel_q) == i) seek_d[i] = SEEK_W'(1);
                    end
                    irq_d = 1'b1;
                  end
                  OP_RECALIBRATE: begin
                    for (int i = 0; i < NUM_DRIVES; i++) begin
                      if (32'(dsel_q) == i) begin
                        seek_d[i] = SEEK_LOAD;
                        cyl_d[i]  = 8'd0;
                      end
                    end
                    irq_d = 1'b1;
                  end
                  OP_SENSE_INT: begin
                    rb_d[0] = irq_q ? 8'd0 : SENSE_NO_INT;
                    rb_d[1] = sel_cyl;
                  end
                  OP_SEEK: begin
                    for (int i = 0; i < NUM_DRIVES; i++) begin
                      if (32'(dsel_q) == i) begin
                        seek_d[i] = SEEK_LOAD;
                        cyl_d[i]  = pv[2];
                      end
                    end
                    irq_d = 1'b1;
                  end
                  OP_PERPENDICULAR, OP_CONFIGURE: begin
                  end
                  default: begin
                    // Unsupported command: drop it
                    done  = 1'b0;
                    err_d = 1'b1;
                  end
                endcase
                if (done) begin
                  ridx_d = '0;
                  rqm_d  = 1'b1;
                  if (rlen != 4'd0) dio_d = 1'b1;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end else begin
        priority if (off == OFF_MSR) begin
          rd_d   = status;
          seek_d = seek_dec;
        end else if (off == OFF_FIFO) begin
          rd_d   = rb_rd;
          ridx_d = ridx_inc;
          if (ridx_inc >= rtot_q) begin
            rqm_d = 1'b1;
            dio_d = 1'b0;
          end
        end else begin
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PARAM_BYTES; i++) pb_q[i] <= 8'd0;
      for (int i = 0; i < MAX_RESULT_BYTES; i++) rb_q[i] <= 8'd0;
      for (int i = 0; i < NUM_DRIVES; i++) begin
        seek_q[i] <= '0;
        cyl_q[i]  <= 8'd0;
      end
      pcnt_q    <= '0;
      ridx_q    <= '0;
      rtot_q    <= '0;
      rqm_q     <= 1'b1;
      dio_q     <= 1'b0;
      irq_q     <= 1'b0;
      motor_a_q <= 1'b0;
      motor_b_q <= 1'b0;
      dma_q     <= 1'b0;
      dsel_q    <= 2'd0;
      rate_q    <= 2'd0;
      precomp_q <= 3'd0;
    end else begin
      pb_q      <= pb_d;
      rb_q      <= rb_d;
      seek_q    <= seek_d;
      cyl_q     <= cyl_d;
      pcnt_q    <= pcnt_d;
      ridx_q    <= ridx_d;
      rtot_q    <= rtot_d;
      rqm_q     <= rqm_d;
      dio_q     <= dio_d;
      irq_q     <= irq_d;
      motor_a_q <= motor_a_d;
      motor_b_q <= motor_b_d;
      dma_q     <= dma_d;
      dsel_q    <= dsel_d;
      rate_q    <= rate_d;
      precomp_q <= precomp_d;
    end
  end

  // Capture the per-item result
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_q   <= rd_d;
      breq_q <= breq_d;
      bidx_q <= bidx_d;
      err_q  <= err_d;
    end
  end

  assign read_data_o         = rd_q;
  assign block_request_o     = breq_q;
  assign block_index_o       = bidx_q;
  assign command_error_o     = err_q;
  assign interrupt_pending_o = irq_q;
  assign motor_a_o           = motor_a_q;
  assign motor_b_o           = motor_b_q;
  assign dma_enable_o        = dma_q;
  assign unit_select_o       = dsel_q;
  assign data_rate_o         = rate_q;
  assign precomp_code_o      = precomp_q;

  `FDC_ASSERT(a_pcnt_range, 32'(pcnt_q) < MAX_PARAM_BYTES, "parameter count out of range")
  `FDC_ASSERT_NEXT(a_read_data_done, cmd_i.exec && breq_d, irq_q && dio_q && (pcnt_q == '0), "read data left bad phase")

endmodule

`default_nettype wire

// ----- sv/floppy_controller_command_port_core.sv -----
// Channel | Handshake                     | Payload
// --------+-------------------------------+------------------------------------------
// in      | in_valid_i / in_stall_o       | command_i, reg_offset_i, write_data_i
// out     | out_valid_o / out_stall_i     | read_data_o ... command_error_o
//
// Each access's result is registered and appears in the next cycle. One access
// per cycle is sustained unless the output stalls: all register updates run in one
// step of the datapath, the slowest path being the 8x8 block address product and add.
// Reset is asynchronous and active low; the command port comes up empty.
// The input stalls only while a result is held and the output side stalls.
`default_nettype none

module floppy_controller_command_port_core #(
  parameter int NUM_DRIVES        = fdc_pkg::NUM_DRIVES_DEF,
  parameter int MAX_PARAM_BYTES   = fdc_pkg::MAX_PARAM_BYTES_DEF,
  parameter int MAX_RESULT_BYTES  = fdc_pkg::MAX_RESULT_BYTES_DEF,
  parameter int SEEK_STATUS_READS = fdc_pkg::SEEK_STATUS_READS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       command_i,
  input  wire logic [2:0]                 reg_offset_i,
  input  wire logic [7:0]                 write_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [7:0]                      read_data_o,
  output logic                            block_request_o,
  output logic [fdc_pkg::BIDX_W-1:0]      block_index_o,
  output logic                            interrupt_pending_o,
  output logic                            motor_a_o,
  output logic                            motor_b_o,
  output logic                            dma_enable_o,
  output logic [1:0]                      unit_select_o,
  output logic [1:0]                      data_rate_o,
  output logic [2:0]                      precomp_code_o,
  output logic                            command_error_o
);
  import fdc_pkg::*;

  ctrl_cmd_t cmd;

  // Handshake and result register control
  fdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Register file and command execution
  fdc_datapath #(
    .NUM_DRIVES        (NUM_DRIVES),
    .MAX_PARAM_BYTES   (MAX_PARAM_BYTES),
    .MAX_RESULT_BYTES  (MAX_RESULT_BYTES),
    .SEEK_STATUS_READS (SEEK_STATUS_READS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .command_i           (command_i),
    .reg_offset_i        (reg_offset_i),
    .write_data_i        (write_data_i),
    .read_data_o         (read_data_o),
    .block_request_o     (block_request_o),
    .block_index_o       (block_index_o),
    .interrupt_pending_o (interrupt_pending_o),
    .motor_a_o           (motor_a_o),
    .motor_b_o           (motor_b_o),
    .dma_enable_o        (dma_enable_o),
    .unit_select_o       (unit_select_o),
    .data_rate_o         (data_rate_o),
    .precomp_code_o      (precomp_code_o),
    .command_error_o     (command_error_o)
  );

endmodule

`default_nettype wire
